### hw/rtl/vdcn_pkg.sv
// Shared types and operation codes for the vector dot/cross/normalize unit.
package vdcn_pkg;

  localparam logic [1:0] FUNC_DOT   = 2'd0;
  localparam logic [1:0] FUNC_CROSS = 2'd1;
  localparam logic [1:0] FUNC_NORM  = 2'd2;
  localparam logic [1:0] FUNC_UNIT  = 2'd3;

  typedef struct packed {
    logic [1:0]   func;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_comp;
    logic signed [31:0] bz;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               overflow;
    logic               zero_length;
  } out_t;

endpackage

### hw/rtl/vdcn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vdcn_sqrt #(
  parameter int RW = 33
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*RW-1:0]     rad,
  output logic [RW-1:0]       root
);

  logic [RW:0]     rem_r   [RW];
  logic [RW-1:0]   rt_r    [RW];
  logic [2*RW-1:0] rad_r   [RW];
  logic [RW:0]     rem_nxt [RW];
  logic [RW-1:0]   rt_nxt  [RW];
  logic [2*RW-1:0] rad_nxt [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]     rem_in;
    logic [RW-1:0]   rt_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+2:0]   cur;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign rad_in = rad;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign rt_in  = rt_r[k-1];
      assign rad_in = rad_r[k-1];
    end

    assign cur   = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;
    assign rem_nxt[k] = ge ? diff[RW:0] : cur[RW:0];
    assign rt_nxt[k]  = {rt_in[RW-2:0], ge};
    assign rad_nxt[k] = {rad_in[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_r[k] <= rem_nxt[k];
        rt_r[k]  <= rt_nxt[k];
        rad_r[k] <= rad_nxt[k];
      end
    end
  end

  assign root = rt_r[RW-1];

endmodule

### hw/rtl/vdcn_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module vdcn_div #(
  parameter int RW = 33,
  parameter int QB = 17,
  parameter int NW = 49
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic [QB-1:0] quot,
  output logic [RW-1:0] divisor_out
);

  logic [RW-1:0] rem_r   [QB];
  logic [QB-1:0] qd_r    [QB];
  logic [RW-1:0] dvs_r   [QB];
  logic [RW-1:0] rem_nxt [QB];
  logic [QB-1:0] qd_nxt  [QB];
  logic [RW-1:0] dvs_nxt [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QB-1:0] qd_in;
    logic [RW-1:0] dvs_in;
    logic [RW:0]   cur;
    logic [RW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = RW'(dividend[NW-1:QB]);
      assign qd_in  = dividend[QB-1:0];
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign qd_in  = qd_r[k-1];
      assign dvs_in = dvs_r[k-1];
    end

    assign cur  = {rem_in, qd_in[QB-1]};
    assign ge   = cur >= {1'b0, dvs_in};
    assign diff = cur - {1'b0, dvs_in};
    assign rem_nxt[k] = ge ? diff[RW-1:0] : cur[RW-1:0];
    assign qd_nxt[k]  = {qd_in[QB-2:0], ge};
    assign dvs_nxt[k] = dvs_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        qd_r[k]  <= qd_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
      end
    end
  end

  assign quot        = qd_r[QB-1];
  assign divisor_out = dvs_r[QB-1];

endmodule

### hw/rtl/vec3_dot_cross_normalize_unit.sv
// Top level of the vector dot/cross/normalize unit.
//
//  channel | ports                       | direction | beat moves when
//  --------+-----------------------------+-----------+---------------------
//  input   | in_valid, in_stall, in_data | to unit   | in_valid && !in_stall
//  result  | out_valid, out_stall, out_data | from unit | out_valid && !out_stall
//
// One beat enters per cycle while the result is not stalled; EFF = min(WORD_BITS,
// 32). Most of the pipeline is the one-bit-per-stage square root (EFF + 1 stages)
// followed by the divider (FRAC_BITS + 1 stages).
// Reset clears the valid bits only; the datapath registers carry no reset.
// A stalled result freezes the whole pipeline; the first stage still fills
// while it is empty.
module vec3_dot_cross_normalize_unit
  import vdcn_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int EFF  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int RW   = EFF + 1;
  localparam int PW   = 2 * EFF;
  localparam int SW   = 2 * RW;
  localparam int SUMW = 2 * EFF + 3;
  localparam int XW   = 2 * EFF + 2;
  localparam int QB   = FRAC_BITS + 1;
  localparam int NW   = EFF + FRAC_BITS + 1;
  localparam int D    = RW + QB;

  typedef struct packed {
    logic [1:0]             func;
    logic [2:0]             an;
    logic [2:0][EFF-1:0]    am;
    logic [3:0][31:0]       res;
    logic                   ovf;
  } side_t;

  function automatic logic [32:0] sat_enc(input logic neg, input logic [XW-1:0] mag);
    logic [XW-1:0] lim;
    logic [XW-1:0] m;
    logic          o;
    lim = XW'(1) << (EFF - 1);
    if (!neg) begin
      lim = lim - XW'(1);
    end
    o = mag > lim;
    m = o ? lim : mag;
    return {o, neg ? (32'd0 - m[31:0]) : m[31:0]};
  endfunction

  function automatic logic [32:0] rnd_sat(input logic signed [SUMW-1:0] v);
    logic          neg;
    logic [XW-1:0] mag;
    neg = v[SUMW-1];
    mag = neg ? XW'(-v) : XW'(v);
    mag = (mag + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return sat_enc(neg, mag);
  endfunction

  function automatic logic signed [SUMW-1:0] term(input logic n, input logic [PW-1:0] m);
    logic signed [SUMW-1:0] t;
    t = $signed(SUMW'(m));
    return n ? -t : t;
  endfunction

  logic adv;
  logic ld1;

  logic                s1_v_r;
  logic [1:0]          s1_func_r;
  logic [2:0]          s1_an_r;
  logic [2:0][EFF-1:0] s1_am_r;
  logic [2:0]          s1_bn_r;
  logic [2:0][EFF-1:0] s1_bm_r;

  logic [2:0][31:0]    raw_a;
  logic [2:0][31:0]    raw_b;
  logic [2:0]          a_n;
  logic [2:0][EFF-1:0] a_m;
  logic [2:0]          b_n;
  logic [2:0][EFF-1:0] b_m;

  logic                s2_v_r;
  logic [1:0]          s2_func_r;
  logic [2:0]          s2_an_r;
  logic [2:0][EFF-1:0] s2_am_r;
  logic [2:0][PW-1:0]  s2_d_r;
  logic [2:0]          s2_dn_r;
  logic [2:0][PW-1:0]  s2_cp_r;
  logic [2:0]          s2_cpn_r;
  logic [2:0][PW-1:0]  s2_cm_r;
  logic [2:0]          s2_cmn_r;
  logic [2:0][PW-1:0]  d_nxt;
  logic [2:0]          dn_nxt;
  logic [2:0][PW-1:0]  cp_nxt;
  logic [2:0]          cpn_nxt;
  logic [2:0][PW-1:0]  cm_nxt;
  logic [2:0]          cmn_nxt;

  logic                   s3_v_r;
  logic [1:0]             s3_func_r;
  logic [2:0]             s3_an_r;
  logic [2:0][EFF-1:0]    s3_am_r;
  logic signed [SUMW-1:0] s3_dot_r;
  logic signed [SUMW-1:0] s3_crs_r [3];

  side_t         sd0_nxt;
  side_t         sd_r [D];
  logic [D-1:0]  sv_r;

  logic [RW-1:0] root;
  logic [QB-1:0] quot [3];
  logic [RW-1:0] dvs  [3];
  logic          zl;

  logic out_valid_r;
  out_t out_data_r;
  out_t out_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign ld1      = adv || !s1_v_r;
  assign in_stall = !ld1;

  assign raw_a = {in_data.az, in_data.ay, in_data.ax};
  assign raw_b = {in_data.bz, in_data.by_comp, in_data.bx};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_n[i] = raw_a[i][EFF-1];
      a_m[i] = a_n[i] ? (~raw_a[i][EFF-1:0] + EFF'(1)) : raw_a[i][EFF-1:0];
      b_n[i] = raw_b[i][EFF-1];
      b_m[i] = b_n[i] ? (~raw_b[i][EFF-1:0] + EFF'(1)) : raw_b[i][EFF-1:0];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_prod
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic          sq;
    logic [EFF-1:0] opb;
    assign sq        = s1_func_r inside {FUNC_NORM, FUNC_UNIT};
    assign opb       = sq ? s1_am_r[i] : s1_bm_r[i];
    assign d_nxt[i]  = PW'(s1_am_r[i]) * PW'(opb);
    assign dn_nxt[i] = sq ? 1'b0 : (s1_an_r[i] ^ s1_bn_r[i]);
    assign cp_nxt[i] = PW'(s1_am_r[J]) * PW'(s1_bm_r[K]);
    assign cpn_nxt[i] = s1_an_r[J] ^ s1_bn_r[K];
    assign cm_nxt[i] = PW'(s1_am_r[K]) * PW'(s1_bm_r[J]);
    assign cmn_nxt[i] = s1_an_r[K] ^ s1_bn_r[J];
  end

  always_comb begin
    logic [32:0] t;
    t            = '0;
    sd0_nxt      = '0;
    sd0_nxt.func = s3_func_r;
    sd0_nxt.an   = s3_an_r;
    sd0_nxt.am   = s3_am_r;
    if (s3_func_r == FUNC_DOT) begin
      t              = rnd_sat(s3_dot_r);
      sd0_nxt.res[3] = t[31:0];
      sd0_nxt.ovf    = t[32];
    end else if (s3_func_r == FUNC_CROSS) begin
      for (int i = 0; i < 3; i++) begin
        t              = rnd_sat(s3_crs_r[i]);
        sd0_nxt.res[i] = t[31:0];
        sd0_nxt.ovf    = sd0_nxt.ovf | t[32];
      end
    end
  end

  vdcn_sqrt #(
    .RW(RW)
  ) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s3_dot_r[SW-1:0]),
    .root (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NW-1:0] dividend;
    assign dividend = (NW'(sd_r[RW-1].am[i]) << FRAC_BITS) + NW'(root >> 1);
    vdcn_div #(
      .RW(RW),
      .QB(QB),
      .NW(NW)
    ) u_div (
      .clk         (clk),
      .en          (adv),
      .dividend    (dividend),
      .divisor     (root),
      .quot        (quot[i]),
      .divisor_out (dvs[i])
    );
  end

  assign zl = ~|{dvs[0], dvs[1], dvs[2]};

  always_comb begin
    logic [32:0] t;
    t       = '0;
    out_nxt = '0;
    if (sd_r[D-1].func inside {FUNC_DOT, FUNC_CROSS}) begin
      out_nxt.rx         = sd_r[D-1].res[0];
      out_nxt.ry         = sd_r[D-1].res[1];
      out_nxt.rz         = sd_r[D-1].res[2];
      out_nxt.scalar_out = sd_r[D-1].res[3];
      out_nxt.overflow   = sd_r[D-1].ovf;
    end else if (zl) begin
      out_nxt.zero_length = 1'b1;
    end else begin
      t = sat_enc(sd_r[D-1].an[0], XW'(quot[0]));
      out_nxt.rx = t[31:0];
      out_nxt.overflow = t[32];
      t = sat_enc(sd_r[D-1].an[1], XW'(quot[1]));
      out_nxt.ry = t[31:0];
      out_nxt.overflow = out_nxt.overflow | t[32];
      t = sat_enc(sd_r[D-1].an[2], XW'(quot[2]));
      out_nxt.rz = t[31:0];
      out_nxt.overflow = out_nxt.overflow | t[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r;
        sv_r        <= {sv_r[D-2:0], s3_v_r};
        out_valid_r <= sv_r[D-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_func_r <= in_data.func;
      s1_an_r   <= a_n;
      s1_am_r   <= a_m;
      s1_bn_r   <= b_n;
      s1_bm_r   <= b_m;
    end
    if (adv) begin
      s2_func_r <= s1_func_r;
      s2_an_r   <= s1_an_r;
      s2_am_r   <= s1_am_r;
      s2_d_r    <= d_nxt;
      s2_dn_r   <= dn_nxt;
      s2_cp_r   <= cp_nxt;
      s2_cpn_r  <= cpn_nxt;
      s2_cm_r   <= cm_nxt;
      s2_cmn_r  <= cmn_nxt;

      s3_func_r <= s2_func_r;
      s3_an_r   <= s2_an_r;
      s3_am_r   <= s2_am_r;
      s3_dot_r  <= term(s2_dn_r[0], s2_d_r[0]) + term(s2_dn_r[1], s2_d_r[1])
                 + term(s2_dn_r[2], s2_d_r[2]);
      for (int i = 0; i < 3; i++) begin
        s3_crs_r[i] <= term(s2_cpn_r[i], s2_cp_r[i]) - term(s2_cmn_r[i], s2_cm_r[i]);
      end

      sd_r[0] <= sd0_nxt;
      for (int j = 1; j < D; j++) begin
        sd_r[j] <= sd_r[j-1];
      end

      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the result register is empty");

  a_zero_len_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.rx == 0 && out_data.ry == 0 && out_data.rz == 0 &&
      out_data.scalar_out == 0 && !out_data.overflow)
    else $error("zero-length result carries nonzero data");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(sv_r) && out_valid_r)
    else $error("pipeline moved during an output stall");

endmodule
